[rtl/core/elpi_pkg.sv]
`default_nettype none

package elpi_pkg;

  // Field widths of the external channels.
  localparam int VAL_W   = 24;
  localparam int DELTA_W = VAL_W + 1;
  localparam int STEP_W  = 7;
  localparam int IDX_W   = 6;

  // Largest step count the input field can carry.
  localparam int STEP_LIMIT = (1 << STEP_W) - 1;

  // Parameter defaults.
  localparam int MAX_STEPS_DEF   = 64;
  localparam int STEPS_NW_DEF    = 7;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Profile codes.
  localparam logic PROF_CUBIC  = 1'b0;
  localparam logic PROF_LINEAR = 1'b1;

  // Fill status of the job queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[rtl/core/elpi_queue.sv]
`default_nettype none

module elpi_queue #(
  parameter int W     = 8,
  parameter int DEPTH = elpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [W-1:0]     push_data,
  input  wire logic             pop,
  output logic [W-1:0]          pop_data,
  output elpi_pkg::q_status_t   status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

[rtl/core/elpi_front.sv]
`default_nettype none

module elpi_front #(
  parameter int COUNT_CAP = elpi_pkg::MAX_STEPS_DEF,
  parameter int NW        = elpi_pkg::STEPS_NW_DEF,
  localparam int DW       = 3 * NW,
  localparam int QW       = 1 + elpi_pkg::VAL_W + elpi_pkg::DELTA_W + NW + DW
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_action,
  input  wire logic signed [elpi_pkg::VAL_W-1:0]  in_start_value,
  input  wire logic signed [elpi_pkg::VAL_W-1:0]  in_end_value,
  input  wire logic [elpi_pkg::STEP_W-1:0]        in_step_count,
  input  wire elpi_pkg::q_status_t                q_status,
  output logic                                    q_push,
  output logic [QW-1:0]                           q_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_CUBE = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]                          state_r;
  logic [1:0]                          state_nxt;
  logic                                profile_r;
  logic [elpi_pkg::VAL_W-1:0]          start_r;
  logic [elpi_pkg::DELTA_W-1:0]        delta_r;
  logic [NW-1:0]                       n_r;
  logic [2*NW-1:0]                     nsq_r;
  logic [DW-1:0]                       den_r;
  logic [NW-1:0]                       n_clamp;
  logic [DW-1:0]                       cube;
  logic                                accept;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign q_push   = (state_r == F_PUSH) && !q_status.full;
  assign q_data   = {profile_r, start_r, delta_r, n_r, den_r};
  assign cube     = nsq_r * n_r;

  // A zero count runs as one step; counts beyond the limit saturate.
  always_comb begin
    priority if (in_step_count == '0) begin
      n_clamp = NW'(1);
    end else if (int'(in_step_count) > COUNT_CAP) begin
      n_clamp = NW'(COUNT_CAP);
    end else begin
      n_clamp = NW'(in_step_count);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_SQ;
      F_SQ:   state_nxt = F_CUBE;
      F_CUBE: state_nxt = F_PUSH;
      F_PUSH: if (!q_status.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      profile_r <= in_action;
      start_r   <= in_start_value;
      delta_r   <= {in_end_value[elpi_pkg::VAL_W-1], in_end_value}
                 - {in_start_value[elpi_pkg::VAL_W-1], in_start_value};
      n_r       <= n_clamp;
    end
    if (state_r == F_SQ) begin
      nsq_r <= n_r * n_r;
    end
    if (state_r == F_CUBE) begin
      den_r <= (profile_r == elpi_pkg::PROF_LINEAR) ? DW'(n_r) : cube;
    end
  end

endmodule

`default_nettype wire

[rtl/core/elpi_back.sv]
`default_nettype none

module elpi_back #(
  parameter int NW  = elpi_pkg::STEPS_NW_DEF,
  localparam int DW = 3 * NW,
  localparam int QW = 1 + elpi_pkg::VAL_W + elpi_pkg::DELTA_W + NW + DW
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire elpi_pkg::q_status_t          q_status,
  input  wire logic [QW-1:0]                q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [elpi_pkg::VAL_W-1:0] out_sample_value,
  output logic [elpi_pkg::IDX_W-1:0]        out_sample_index,
  output logic                              out_last_sample
);

  localparam int VW    = elpi_pkg::VAL_W;
  localparam int PW    = elpi_pkg::DELTA_W + DW + 1;
  localparam int MW    = VW + DW;
  localparam int SW    = VW + 2;
  localparam int CNT_W = $clog2(VW);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_W1   = 3'd1;
  localparam logic [2:0] B_W2   = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_ABS  = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_FIX  = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]                          state_r;
  logic [2:0]                          state_nxt;

  logic                                q_prof;
  logic [VW-1:0]                       q_start;
  logic [elpi_pkg::DELTA_W-1:0]        q_delta;
  logic [NW-1:0]                       q_n;
  logic [DW-1:0]                       q_den;

  logic                                profile_r;
  logic [VW-1:0]                       start_r;
  logic signed [elpi_pkg::DELTA_W-1:0] delta_r;
  logic [NW-1:0]                       n_r;
  logic [DW-1:0]                       den_r;
  logic [NW-1:0]                       i_r;
  logic [elpi_pkg::IDX_W-1:0]          idx_r;
  logic [2*NW-1:0]                     sq_r;
  logic [DW-1:0]                       w_r;
  logic signed [PW-1:0]                prod_r;
  logic                                neg_r;
  logic [DW-1:0]                       rem_r;
  logic [VW-1:0]                       lo_r;
  logic [VW-1:0]                       quo_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [VW-1:0]                       val_r;
  logic                                last_r;

  logic                                out_valid_r;
  logic [VW-1:0]                       out_value_r;
  logic [elpi_pkg::IDX_W-1:0]          out_index_r;
  logic                                out_last_r;

  logic                                is_last;
  logic [2*NW-1:0]                     sq_w;
  logic [NW+1:0]                       wfac;
  logic [3*NW+1:0]                     wfull;
  logic signed [PW-1:0]                prod_w;
  logic [PW-1:0]                       mag;
  logic [DW:0]                         trial;
  logic                                ge;
  logic                                rnd;
  logic [SW-1:0]                       qext;
  logic [SW-1:0]                       offset;
  logic [SW-1:0]                       vsum;
  logic [elpi_pkg::DELTA_W-1:0]        end_sum;
  logic                                load;

  assign {q_prof, q_start, q_delta, q_n, q_den} = q_data;

  assign q_pop   = (state_r == B_IDLE) && !q_status.empty;
  assign is_last = (i_r == n_r);
  assign sq_w    = i_r * i_r;
  // 3n - 2i stays positive since i never exceeds n.
  assign wfac    = ({2'b00, n_r} << 1) + {2'b00, n_r} - ({2'b00, i_r} << 1);
  assign wfull   = sq_r * wfac;
  assign prod_w  = delta_r * $signed({1'b0, w_r});
  assign mag     = prod_r[PW-1] ? (~prod_r + 1'b1) : prod_r;

  // One restoring division step per cycle.
  assign trial   = {rem_r, lo_r[VW-1]};
  assign ge      = (trial >= {1'b0, den_r});

  // Floor of a negative quotient rounds away from zero when inexact.
  assign rnd     = neg_r && (rem_r != '0);
  assign qext    = {2'b00, quo_r} + SW'(rnd);
  assign offset  = neg_r ? (~qext + 1'b1) : qext;
  assign vsum    = {{2{start_r[VW-1]}}, start_r} + offset;
  assign end_sum = {start_r[VW-1], start_r} + delta_r;

  assign load    = (state_r == B_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_status.empty) state_nxt = B_W1;
      B_W1: begin
        priority if (is_last) begin
          state_nxt = B_OUT;
        end else if (profile_r == elpi_pkg::PROF_LINEAR) begin
          state_nxt = B_MUL;
        end else begin
          state_nxt = B_W2;
        end
      end
      B_W2:  state_nxt = B_MUL;
      B_MUL: state_nxt = B_ABS;
      B_ABS: state_nxt = B_DIV;
      B_DIV: if (cnt_r == CNT_W'(VW - 1)) state_nxt = B_FIX;
      B_FIX: state_nxt = B_OUT;
      B_OUT: if (load) state_nxt = last_r ? B_IDLE : B_W1;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          profile_r <= q_prof;
          start_r   <= q_start;
          delta_r   <= q_delta;
          n_r       <= q_n;
          den_r     <= q_den;
          i_r       <= NW'(1);
          idx_r     <= '0;
        end
      end
      B_W1: begin
        sq_r   <= sq_w;
        w_r    <= DW'(i_r);
        last_r <= is_last;
        val_r  <= end_sum[VW-1:0];
      end
      B_W2: begin
        w_r <= wfull[DW-1:0];
      end
      B_MUL: begin
        prod_r <= prod_w;
      end
      B_ABS: begin
        neg_r <= prod_r[PW-1];
        rem_r <= mag[MW-1:VW];
        lo_r  <= mag[VW-1:0];
        quo_r <= '0;
        cnt_r <= '0;
      end
      B_DIV: begin
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        lo_r  <= lo_r << 1;
        quo_r <= {quo_r[VW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      B_FIX: begin
        val_r <= vsum[VW-1:0];
      end
      B_OUT: begin
        if (load) begin
          i_r   <= i_r + 1'b1;
          idx_r <= idx_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (load) begin
      out_value_r <= val_r;
      out_index_r <= idx_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_sample_index = out_index_r;
  assign out_last_sample  = out_last_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < den_r))
    else $error("division remainder reached the divisor");

  a_cubic_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_W2) |-> (i_r < n_r))
    else $error("curve weight computed for the final sample");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_valid_r && !out_ready) |=> (state_r == B_OUT))
    else $error("sample engine moved on while the output was stalled");

endmodule

`default_nettype wire

[rtl/core/ease_or_linear_path_interpolator.sv]
// Path interpolator: each input beat carries a start value, an end value, a
// step count n and a profile (0 = cubic ease in-out, 1 = linear). The block
// answers with n output beats, sample i = start + floor(delta * w_i) for
// i = 1..n, where w_i = i*i*(3n - 2i) / n^3 for the cubic curve and i / n for
// the linear one; the final beat is exactly the end value and has
// out_last_sample set. Values are signed fixed point and keep their format.
// A step count of zero runs as one step, and counts above MAX_STEPS are
// saturated to MAX_STEPS. The sample index is zero based and wraps in six
// bits. A front end takes one request at a time: it clamps the count and
// forms the delta and n^3 (n if linear) on a small multiplier, and takes no
// new request until the job is parked in a QUEUE_DEPTH entry queue, so new
// requests are taken while an earlier run is still being emitted. The back
// end produces one sample at a time: each sample before the last forms its
// weight (with the extra 3n - 2i factor for the cubic curve), multiplies it
// by the delta, takes the magnitude, runs a 24 step restoring divider that
// retires one quotient bit per cycle and adds the start back in; the final
// sample is the end value itself. The output is a register, so the back end
// keeps working on the next sample while a finished one waits for out_ready.

`default_nettype none

module ease_or_linear_path_interpolator #(
  parameter int MAX_STEPS   = elpi_pkg::MAX_STEPS_DEF,
  parameter int QUEUE_DEPTH = elpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_action,
  input  wire logic signed [elpi_pkg::VAL_W-1:0]  in_start_value,
  input  wire logic signed [elpi_pkg::VAL_W-1:0]  in_end_value,
  input  wire logic [elpi_pkg::STEP_W-1:0]        in_step_count,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [elpi_pkg::VAL_W-1:0]       out_sample_value,
  output logic [elpi_pkg::IDX_W-1:0]              out_sample_index,
  output logic                                    out_last_sample
);

  // The input field caps the count anyway, so widths follow the smaller limit.
  localparam int COUNT_CAP = (MAX_STEPS < elpi_pkg::STEP_LIMIT) ?
                             MAX_STEPS : elpi_pkg::STEP_LIMIT;
  localparam int NW        = $clog2(COUNT_CAP + 1);
  localparam int DW        = 3 * NW;
  localparam int QW        = 1 + elpi_pkg::VAL_W + elpi_pkg::DELTA_W + NW + DW;

  logic                 q_push;
  logic                 q_pop;
  logic [QW-1:0]        push_data;
  logic [QW-1:0]        pop_data;
  elpi_pkg::q_status_t  q_status;

  elpi_front #(
    .COUNT_CAP (COUNT_CAP),
    .NW        (NW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_start_value (in_start_value),
    .in_end_value   (in_end_value),
    .in_step_count  (in_step_count),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_data         (push_data)
  );

  elpi_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  elpi_back #(
    .NW (NW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .q_data           (pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_sample_index (out_sample_index),
    .out_last_sample  (out_last_sample)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the eased or linear path interpolator.
//
// Every request beat that the block takes is expanded right away into the
// sample beats it must produce. Those expected beats wait in a queue, and
// each sample beat the block delivers is checked field by field against
// the oldest one.
module tb_top;

  localparam int VAL_W  = elpi_pkg::VAL_W;
  localparam int STEP_W = elpi_pkg::STEP_W;
  localparam int IDX_W  = elpi_pkg::IDX_W;

  // One request as the sender offers it. When hold_for_drain is set, the
  // sender waits until every expected sample has come back before it offers
  // this request.
  typedef struct {
    logic                     profile;
    logic signed [VAL_W-1:0]  from_value;
    logic signed [VAL_W-1:0]  to_value;
    logic [STEP_W-1:0]        count;
    bit                       hold_for_drain;
  } path_request_t;

  // One sample beat as the block must deliver it.
  typedef struct {
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         index;
    logic                     last;
  } path_sample_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_action = elpi_pkg::PROF_CUBIC;
  logic signed [VAL_W-1:0]  in_start_value = '0;
  logic signed [VAL_W-1:0]  in_end_value = '0;
  logic [STEP_W-1:0]        in_step_count = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VAL_W-1:0]  out_sample_value;
  logic [IDX_W-1:0]         out_sample_index;
  logic                     out_last_sample;

  path_request_t  request_q[$];
  path_sample_t   expected_samples[$];
  path_request_t  next_request;
  path_sample_t   wanted_sample;

  int unsigned requests_taken = 0;
  int unsigned samples_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_left = 0;
  bit          long_stall_done = 1'b0;

  ease_or_linear_path_interpolator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_start_value   (in_start_value),
    .in_end_value     (in_end_value),
    .in_step_count    (in_step_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_sample_index (out_sample_index),
    .out_last_sample  (out_last_sample)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Quotient rounded toward minus infinity, which is what dropping the low
  // bits of a two's complement product gives. The divisor is always positive.
  function automatic longint floor_quotient(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Expands one accepted request into its sample beats. A step count of zero
  // runs as a single step and counts above the maximum are clipped to it.
  // The cubic weight is i*i*(3n - 2i) / n^3, the linear one i / n, and the
  // final sample is pinned to the end value.
  function automatic void plan_path_samples(logic profile, logic signed [VAL_W-1:0] from_v,
                                            logic signed [VAL_W-1:0] to_v,
                                            logic [STEP_W-1:0] count);
    longint       n;
    longint       delta;
    longint       weight_num;
    longint       weight_den;
    longint       point;
    path_sample_t s;
    n = longint'(count);
    if (n == 0) begin
      n = 1;
    end
    if (n > elpi_pkg::MAX_STEPS_DEF) begin
      n = elpi_pkg::MAX_STEPS_DEF;
    end
    delta = longint'(to_v) - longint'(from_v);
    for (longint i = 1; i <= n; i++) begin
      if (i == n) begin
        point = longint'(to_v);
      end else if (profile == elpi_pkg::PROF_CUBIC) begin
        weight_num = i * i * (3 * n - 2 * i);
        weight_den = n * n * n;
        point = longint'(from_v) + floor_quotient(delta * weight_num, weight_den);
      end else begin
        point = longint'(from_v) + floor_quotient(delta * i, n);
      end
      s.value = point[VAL_W-1:0];
      s.index = IDX_W'(i - 1);
      s.last  = (i == n);
      expected_samples.push_back(s);
    end
  endfunction

  task automatic add_request(logic profile, int from_v, int to_v, int count,
                             bit hold_for_drain = 1'b0);
    path_request_t r;
    r.profile        = profile;
    r.from_value     = VAL_W'(from_v);
    r.to_value       = VAL_W'(to_v);
    r.count          = STEP_W'(count);
    r.hold_for_drain = hold_for_drain;
    request_q.push_back(r);
  endtask

  // Random request. Step counts are mostly small so the run stays short;
  // a few go to the maximum and a few past it to exercise the clipping.
  // Values are either fully random, close together, or taken from the
  // corners of the range.
  task automatic add_random_request(bit hold_for_drain);
    int from_v;
    int to_v;
    int count;
    int pick;
    int corners[4];
    corners = '{-8388608, 8388607, 0, -1};
    pick = $urandom_range(99);
    if (pick < 70) begin
      count = $urandom_range(8, 0);
    end else if (pick < 90) begin
      count = $urandom_range(31, 9);
    end else if (pick < 97) begin
      count = $urandom_range(64, 32);
    end else begin
      count = $urandom_range(127, 65);
    end
    from_v = $urandom;
    case ($urandom_range(3))
      0: begin
        to_v = $urandom;
      end
      1: begin
        to_v = from_v + $urandom_range(2000) - 1000;
      end
      2: begin
        from_v = corners[$urandom_range(3)];
        to_v = corners[$urandom_range(3)];
      end
      default: begin
        to_v = from_v + $urandom_range(65535) - 32768;
      end
    endcase
    add_request(1'($urandom_range(1)), from_v, to_v, count, hold_for_drain);
  endtask

  // Sender. A new beat is set up only once the current one has been taken.
  // It holds back at random, at odds of 13 in 100, except for a stretch of
  // requests where it offers back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        plan_path_samples(in_action, in_start_value, in_end_value, in_step_count);
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_q[0].hold_for_drain && expected_samples.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!(requests_taken >= 120 && requests_taken < 170) &&
                     $urandom_range(99) < 13) begin
          in_valid <= 1'b0;
        end else begin
          next_request = request_q.pop_front();
          in_valid <= 1'b1;
          in_action <= next_request.profile;
          in_start_value <= next_request.from_value;
          in_end_value <= next_request.to_value;
          in_step_count <= next_request.count;
        end
      end
    end
  end

  // Receiver and checker. Once sixty requests have gone in, the receiver
  // refuses samples in a single stall while the sender keeps
  // offering, which backs the block up until it stops taking requests.
  // Outside that, it stalls at random, at odds of 13 in 100, but never while
  // a window of sample beats is being received.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        samples_seen <= samples_seen + 1;
        if (expected_samples.size() == 0) begin
          $error("sample beat with nothing expected: value %0d index %0d last %0b",
                 out_sample_value, out_sample_index, out_last_sample);
          mismatch_count++;
        end else begin
          wanted_sample = expected_samples.pop_front();
          if (out_sample_value !== wanted_sample.value) begin
            $error("sample_value: expected %0d, got %0d", wanted_sample.value,
                   out_sample_value);
            mismatch_count++;
          end
          if (out_sample_index !== wanted_sample.index) begin
            $error("sample_index: expected %0d, got %0d", wanted_sample.index,
                   out_sample_index);
            mismatch_count++;
          end
          if (out_last_sample !== wanted_sample.last) begin
            $error("last_sample: expected %0b, got %0b", wanted_sample.last,
                   out_last_sample);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!long_stall_done && requests_taken >= 60) begin
        stall_left <= 3000;
        long_stall_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (samples_seen >= 600 && samples_seen < 1200) ||
                     ($urandom_range(99) >= 13);
      end
    end
  end

  // Stimulus and end of run. The directed requests cover the range corners
  // in both directions, both profiles, a zero difference, tiny negative
  // differences where flooring matters, a zero step count, counts past the
  // maximum, and the shortest runs. The first random request, and one later
  // on, wait until every outstanding sample has come back.
  initial begin
    add_request(elpi_pkg::PROF_LINEAR, 0, 256, 1);
    add_request(elpi_pkg::PROF_CUBIC, -8388608, 8388607, 64);
    add_request(elpi_pkg::PROF_LINEAR, 8388607, -8388608, 64);
    add_request(elpi_pkg::PROF_CUBIC, 8388607, -8388608, 7);
    add_request(elpi_pkg::PROF_LINEAR, -8388608, 8388607, 5);
    add_request(elpi_pkg::PROF_CUBIC, 1000, 1000, 4);
    add_request(elpi_pkg::PROF_CUBIC, 0, -1, 3);
    add_request(elpi_pkg::PROF_LINEAR, 0, -1, 3);
    add_request(elpi_pkg::PROF_CUBIC, 0, 255, 0);
    add_request(elpi_pkg::PROF_LINEAR, -5, 5, 0);
    add_request(elpi_pkg::PROF_CUBIC, 100, -100, 127);
    add_request(elpi_pkg::PROF_LINEAR, -100, 100, 65);
    add_request(elpi_pkg::PROF_CUBIC, -300, 300, 2);
    add_request(elpi_pkg::PROF_LINEAR, 12345, -54321, 2);
    add_request(elpi_pkg::PROF_CUBIC, 'h555555, 'haaaaaa, 63);
    add_request(elpi_pkg::PROF_LINEAR, 'haaaaaa, 'h555555, 9);
    for (int k = 0; k < 214; k++) begin
      add_random_request(k == 0 || k == 100);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Checked on the falling edge so that the sender's and the checker's
    // updates from the rising edge have settled.
    while (request_q.size() != 0 || in_valid) @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ease_or_linear_path_interpolator: match");
    end else begin
      $display("ease_or_linear_path_interpolator: mismatch");
    end
    $finish;
  end

  // This limit allows several times as long as a run with every request at
  // the maximum step count would take.
  initial begin
    #30_000_000;
    $display("ease_or_linear_path_interpolator: mismatch");
    $finish;
  end

endmodule
